/* rtl/efad_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, reset values and sizes for the earliest-free agent dispatcher.
// No dependencies; imported by earliest_free_agent_dispatch.
package efad_pkg;

    localparam int MAX_AGENTS_DEF = 64;
    localparam int CFG_W          = 7;
    localparam int DUR_W          = 16;
    localparam int IDX_W          = 7;
    localparam int TIME_W         = 32;
    localparam int CNT_W          = 32;
    localparam int OUT_W          = IDX_W + TIME_W + CNT_W;
    localparam int OUT_TDATA_W    = ((OUT_W + 7) / 8) * 8;

    localparam logic [CFG_W-1:0] NUM_AGENTS_RST = CFG_W'(64);

    typedef logic [TIME_W-1:0] time_val_t;
    typedef logic [CNT_W-1:0]  cnt_val_t;

endpackage

/* rtl/earliest_free_agent_dispatch.sv */
`timescale 1ns / 1ps
// Earliest-free agent dispatcher: a call goes to the agent that frees up first.
// Depends on efad_pkg for widths and reset values.
//
// Usage: a beat on the s_ channel is a request. With s_tuser low it dispatches a
// call of length s_tdata; one result beat follows with the chosen agent, its start
// time and its new served count, with m_tlast high. With s_tuser high it reports
// every active agent's count in index order, one beat per agent, start time zero,
// m_tlast on the final one. The user must write the agent count through cfg_we/cfg_wdata
// only while the block is idle; the block itself does not enforce this. Zero acts as one,
// values above MAX_AGENTS as MAX_AGENTS. Free times and counts live in two single-port
// memories with a registered read. A dispatch reads every active entry once to find the
// smallest free time in ST_SCAN, then passes ST_LAST and ST_WRITE, where its result is
// loaded into the output register. A report reads each entry in ST_RRD and loads its beat
// in ST_RPT. One request is worked on at a time; s_tready is high only between requests.
// Results pass through one output register, so a new request is accepted while the last
// result waits. When the receiver stalls, the block holds in ST_WRITE or ST_RPT until
// the output register empties.
// After reset all free times and counts read as zero through per-entry valid bits,
// and the agent count is 64.
module earliest_free_agent_dispatch #(
    parameter int MAX_AGENTS = efad_pkg::MAX_AGENTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [efad_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: call_duration.
    input  logic [efad_pkg::DUR_W-1:0]          s_tdata,
    // s_tuser: req_type.
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: agent_index, start_time, served_count, then zero fill.
    output logic [efad_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast
);
    import efad_pkg::*;

    localparam int AW = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
    localparam int CW = $clog2(MAX_AGENTS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_LAST  = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_RRD   = 3'd4;
    localparam logic [2:0] ST_RPT   = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [CFG_W-1:0]      num_agents_reg;
    logic [CW-1:0]         n_act;
    logic [AW-1:0]         idx_reg;
    logic [DUR_W-1:0]      dur_reg;
    logic [MAX_AGENTS-1:0] vld_reg;

    time_val_t free_mem [MAX_AGENTS];
    cnt_val_t  cnt_mem  [MAX_AGENTS];
    time_val_t free_rd_reg;
    cnt_val_t  cnt_rd_reg;
    logic      vld_rd_reg;
    logic      mem_re, mem_we;

    logic      cmp_vld_reg;
    logic [AW-1:0] cmp_idx_reg;
    time_val_t eff_free;
    cnt_val_t  eff_cnt;
    time_val_t best_free_reg;
    cnt_val_t  best_cnt_reg;
    logic [AW-1:0] best_idx_reg;

    logic [TIME_W:0] free_sum;
    time_val_t new_free;
    cnt_val_t  new_cnt;
    logic      idx_last;
    logic      out_free, load_out;

    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                   m_tvalid_reg, m_tlast_reg;

    always_comb
    begin
        if (num_agents_reg == '0)
        begin
            n_act = CW'(1);
        end
        else if (num_agents_reg > CFG_W'(MAX_AGENTS))
        begin
            n_act = CW'(MAX_AGENTS);
        end
        else
        begin
            n_act = CW'(num_agents_reg);
        end
    end

    assign idx_last = (CW'(idx_reg) == n_act - CW'(1));
    assign out_free = !m_tvalid_reg || m_tready;
    assign eff_free = vld_rd_reg ? free_rd_reg : '0;
    assign eff_cnt  = vld_rd_reg ? cnt_rd_reg : '0;

    assign free_sum = {1'b0, best_free_reg} + (TIME_W + 1)'(dur_reg);
    assign new_free = free_sum[TIME_W] ? '1 : free_sum[TIME_W-1:0];
    assign new_cnt  = (best_cnt_reg == '1) ? best_cnt_reg : best_cnt_reg + CNT_W'(1);

    assign mem_re   = (state_reg == ST_SCAN) || (state_reg == ST_RRD);
    assign mem_we   = (state_reg == ST_WRITE) && out_free;
    assign load_out = mem_we || ((state_reg == ST_RPT) && out_free);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = s_tuser ? ST_RRD : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_last)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RRD:
            begin
                state_next = ST_RPT;
            end
            ST_RPT:
            begin
                if (out_free)
                begin
                    state_next = idx_last ? ST_IDLE : ST_RRD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            num_agents_reg <= NUM_AGENTS_RST;
            vld_reg        <= '0;
            cmp_vld_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= (state_reg == ST_SCAN);
            if (cfg_we)
            begin
                num_agents_reg <= cfg_wdata;
            end
            if (mem_we)
            begin
                vld_reg[best_idx_reg] <= 1'b1;
            end
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            free_mem[best_idx_reg] <= new_free;
            cnt_mem[best_idx_reg]  <= new_cnt;
        end
        if (mem_re)
        begin
            free_rd_reg <= free_mem[idx_reg];
            cnt_rd_reg  <= cnt_mem[idx_reg];
            vld_rd_reg  <= vld_reg[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            idx_reg <= '0;
            dur_reg <= s_tdata;
        end
        else if ((state_reg == ST_SCAN) || ((state_reg == ST_RPT) && out_free))
        begin
            idx_reg <= idx_reg + AW'(1);
        end

        cmp_idx_reg <= idx_reg;
        if (cmp_vld_reg && ((cmp_idx_reg == '0) || (eff_free < best_free_reg)))
        begin
            best_free_reg <= eff_free;
            best_cnt_reg  <= eff_cnt;
            best_idx_reg  <= cmp_idx_reg;
        end

        if (mem_we)
        begin
            m_tdata_reg <= OUT_TDATA_W'({new_cnt, best_free_reg,
                                         IDX_W'(best_idx_reg) + IDX_W'(1)});
            m_tlast_reg <= 1'b1;
        end
        else if (load_out)
        begin
            m_tdata_reg <= OUT_TDATA_W'({eff_cnt, time_val_t'(0),
                                         IDX_W'(idx_reg) + IDX_W'(1)});
            m_tlast_reg <= idx_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!m_tvalid_reg || m_tready))
        else $error("Output register loaded while a result was still pending.");

    a_dispatch_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (m_tvalid && m_tlast))
        else $error("Dispatch result not marked as the last beat.");

    a_valid_bits_grow: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> ((($past(vld_reg) & ~vld_reg) == '0) && $countones(vld_reg) > 0))
        else $error("An entry valid bit was lost after a write.");

endmodule
